[rtl/cd_pkg.sv]
// Types, constants and step functions shared by the complex divider.
`default_nettype none
package cd_pkg;

    localparam int DATA_WIDTH = 16;
    localparam int FRAC_BITS  = 16;
    localparam int OUT_W      = 32;
    localparam int PROD_W     = 2 * DATA_WIDTH;
    localparam int NORM_W     = PROD_W;
    localparam int DIVD_W     = PROD_W + FRAC_BITS;
    localparam int REM_W      = NORM_W + 1;
    localparam int Q_W        = OUT_W + 1;
    localparam int STEPS      = DIVD_W;

    localparam logic [OUT_W-1:0] SAT_POS = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic [OUT_W-1:0] SAT_NEG = {1'b1, {(OUT_W-1){1'b0}}};

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_DIVZ = 2'd1,
        ST_OVF  = 2'd2
    } status_t;

    // one quotient part in flight through the divider row
    typedef struct packed {
        logic [DIVD_W-1:0] divd;
        logic [NORM_W-1:0] rem;
        logic [Q_W-1:0]    q;
        logic              hi;
        logic              neg;
    } lane_t;

    typedef struct packed {
        logic [NORM_W-1:0] den;
        logic              zero;
        lane_t             re;
        lane_t             im;
    } item_t;

    typedef struct packed {
        logic [OUT_W-1:0] val;
        logic             ovf;
    } sat_t;

    // one restoring division step
    function automatic lane_t lane_step(input lane_t l, input logic [NORM_W-1:0] den);
        logic [REM_W-1:0] r2;
        logic [REM_W-1:0] diff;
        logic             ge;
        lane_t            o;
        r2   = {l.rem, l.divd[DIVD_W-1]};
        diff = r2 - {1'b0, den};
        ge   = (r2 >= {1'b0, den});
        o       = l;
        o.rem   = ge ? diff[NORM_W-1:0] : r2[NORM_W-1:0];
        o.divd  = l.divd << 1;
        o.q     = {l.q[Q_W-2:0], ge};
        o.hi    = l.hi | l.q[Q_W-1];
        return o;
    endfunction

    // signed result with saturation on magnitude
    function automatic sat_t lane_sat(input lane_t l);
        sat_t o;
        logic big;
        big = l.hi | l.q[Q_W-1];
        if (l.neg) begin
            if (big || (l.q[OUT_W-1] && (|l.q[OUT_W-2:0]))) begin
                o.val = SAT_NEG;
                o.ovf = 1'b1;
            end else begin
                o.val = OUT_W'(-l.q[OUT_W-1:0]);
                o.ovf = 1'b0;
            end
        end else begin
            if (big || l.q[OUT_W-1]) begin
                o.val = SAT_POS;
                o.ovf = 1'b1;
            end else begin
                o.val = l.q[OUT_W-1:0];
                o.ovf = 1'b0;
            end
        end
        return o;
    endfunction

endpackage
`default_nettype wire

[rtl/cd_front.sv]
// Front end: conjugate products, norm and numerator magnitudes over two stages.
`default_nettype none
module cd_front (
    input  wire                                       aclk,
    input  wire                                       aresetn,
    input  wire                                       en,
    input  wire                                       in_valid,
    input  wire  signed [cd_pkg::DATA_WIDTH-1:0]      ar,
    input  wire  signed [cd_pkg::DATA_WIDTH-1:0]      ai,
    input  wire  signed [cd_pkg::DATA_WIDTH-1:0]      br,
    input  wire  signed [cd_pkg::DATA_WIDTH-1:0]      bi,
    output logic                                      out_valid,
    output cd_pkg::item_t                             out_item
);

    logic                               v1_reg, v2_reg;
    logic signed [cd_pkg::PROD_W-1:0]   pa_reg, pb_reg, pc_reg, pd_reg, pn1_reg, pn2_reg;
    logic signed [cd_pkg::PROD_W:0]     sum_re, sum_im;
    logic [cd_pkg::NORM_W-1:0]          norm;
    logic [cd_pkg::PROD_W-1:0]          mag_re, mag_im;
    cd_pkg::item_t                      item_next, item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pa_reg   <= ar * br;
            pb_reg   <= ai * bi;
            pc_reg   <= ai * br;
            pd_reg   <= ar * bi;
            pn1_reg  <= br * br;
            pn2_reg  <= bi * bi;
            item_reg <= item_next;
        end
    end

    always_comb begin
        sum_re = (cd_pkg::PROD_W+1)'(pa_reg) + (cd_pkg::PROD_W+1)'(pb_reg);
        sum_im = (cd_pkg::PROD_W+1)'(pc_reg) - (cd_pkg::PROD_W+1)'(pd_reg);
        norm   = cd_pkg::NORM_W'(pn1_reg) + cd_pkg::NORM_W'(pn2_reg);
        mag_re = sum_re[cd_pkg::PROD_W] ? cd_pkg::PROD_W'(-sum_re) : cd_pkg::PROD_W'(sum_re);
        mag_im = sum_im[cd_pkg::PROD_W] ? cd_pkg::PROD_W'(-sum_im) : cd_pkg::PROD_W'(sum_im);

        item_next         = '0;
        item_next.den     = norm;
        item_next.zero    = (norm == '0);
        item_next.re.divd = cd_pkg::DIVD_W'(mag_re) << cd_pkg::FRAC_BITS;
        item_next.re.neg  = sum_re[cd_pkg::PROD_W];
        item_next.im.divd = cd_pkg::DIVD_W'(mag_im) << cd_pkg::FRAC_BITS;
        item_next.im.neg  = sum_im[cd_pkg::PROD_W];
    end

    assign out_valid = v2_reg;
    assign out_item  = item_reg;

endmodule
`default_nettype wire

[rtl/cd_cell.sv]
// One divider cell: a single restoring step on both quotient parts.
`default_nettype none
module cd_cell (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 en,
    input  wire                 in_valid,
    input  wire cd_pkg::item_t  in_item,
    output logic                out_valid,
    output cd_pkg::item_t       out_item
);

    logic          valid_reg;
    cd_pkg::item_t item_next, item_reg;

    always_comb begin
        item_next    = in_item;
        item_next.re = cd_pkg::lane_step(in_item.re, in_item.den);
        item_next.im = cd_pkg::lane_step(in_item.im, in_item.den);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule
`default_nettype wire

[rtl/complex_divide.sv]
// Complex divider top level: front end, row of divider cells, saturating output register.
//
// Input channel s_*: dividend and divisor parts, signed DATA_WIDTH-bit, one beat
// per division. Output channel m_*: quotient parts in signed Q16.16 and status
// (0 ok, 1 divisor zero with both parts zero, 2 saturated).
// Stages: two front-end stages of products and sums, one quotient bit per cell in the
// cell row (DATA_WIDTH*2 + FRAC_BITS = 48 cells), and one output register.
// Throughput: one beat per cycle while the output is not stalled; every cell
// holds a different division.
// The whole pipe moves on one enable: when an output beat waits unclaimed,
// the pipe holds and s_ready falls; a new beat is still taken while the output
// register is empty or being drained in the same cycle.
// Reset (aresetn low at a clock edge) clears all valid flags; beats in flight
// are dropped. No clearing pass is needed.
`default_nettype none
module complex_divide (
    input  wire                                  aclk,
    input  wire                                  aresetn,
    input  wire                                  s_valid,
    output logic                                 s_ready,
    input  wire  signed [cd_pkg::DATA_WIDTH-1:0] s_dividend_real,
    input  wire  signed [cd_pkg::DATA_WIDTH-1:0] s_dividend_imag,
    input  wire  signed [cd_pkg::DATA_WIDTH-1:0] s_divisor_real,
    input  wire  signed [cd_pkg::DATA_WIDTH-1:0] s_divisor_imag,
    output logic                                 m_valid,
    input  wire                                  m_ready,
    output logic signed [cd_pkg::OUT_W-1:0]      m_quotient_real,
    output logic signed [cd_pkg::OUT_W-1:0]      m_quotient_imag,
    output logic [1:0]                           m_status
);

    logic                          adv;
    logic                          row_valid [cd_pkg::STEPS+1];
    cd_pkg::item_t                 row_item  [cd_pkg::STEPS+1];
    cd_pkg::sat_t                  sat_re, sat_im;
    logic                          m_valid_reg;
    logic [cd_pkg::OUT_W-1:0]      re_reg, re_next, im_reg, im_next;
    cd_pkg::status_t               st_reg, st_next;

    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv;

    cd_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (s_valid),
        .ar        (s_dividend_real),
        .ai        (s_dividend_imag),
        .br        (s_divisor_real),
        .bi        (s_divisor_imag),
        .out_valid (row_valid[0]),
        .out_item  (row_item[0])
    );

    for (genvar g = 0; g < cd_pkg::STEPS; g++) begin : g_cell
        cd_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (adv),
            .in_valid  (row_valid[g]),
            .in_item   (row_item[g]),
            .out_valid (row_valid[g+1]),
            .out_item  (row_item[g+1])
        );
    end

    always_comb begin
        sat_re = cd_pkg::lane_sat(row_item[cd_pkg::STEPS].re);
        sat_im = cd_pkg::lane_sat(row_item[cd_pkg::STEPS].im);
        if (row_item[cd_pkg::STEPS].zero) begin
            re_next = '0;
            im_next = '0;
            st_next = cd_pkg::ST_DIVZ;
        end else begin
            re_next = sat_re.val;
            im_next = sat_im.val;
            st_next = (sat_re.ovf || sat_im.ovf) ? cd_pkg::ST_OVF : cd_pkg::ST_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= row_valid[cd_pkg::STEPS];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            re_reg <= re_next;
            im_reg <= im_next;
            st_reg <= st_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_quotient_real = re_reg;
    assign m_quotient_imag = im_reg;
    assign m_status        = st_reg;

    a_divz_zero : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == cd_pkg::ST_DIVZ) |-> (m_quotient_real == '0) &&
        (m_quotient_imag == '0))
        else $error("divisor-zero beat with nonzero quotient");

    a_status_code : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status == cd_pkg::ST_OK) || (m_status == cd_pkg::ST_DIVZ) ||
        (m_status == cd_pkg::ST_OVF))
        else $error("reserved status code");

    a_ovf_limit : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == cd_pkg::ST_OVF) |->
        (m_quotient_real == cd_pkg::SAT_POS) || (m_quotient_real == cd_pkg::SAT_NEG) ||
        (m_quotient_imag == cd_pkg::SAT_POS) || (m_quotient_imag == cd_pkg::SAT_NEG))
        else $error("overflow status without a saturated part");

    a_row_hold : assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> $stable(row_valid[cd_pkg::STEPS]))
        else $error("cell row moved while output stalled");

endmodule
`default_nettype wire
